### rtl/fcvd_pkg.sv
// Shared types and constants for the front-coded vocabulary decoder.
// No dependencies; used by every module of the block.
package fcvd_pkg;

    localparam int GROUP_W = 12;
    localparam int CLASS_W = 12;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_CHAR = 2'd0,
        KIND_REC  = 2'd1,
        KIND_ERR  = 2'd2
    } kind_t;

    // One result item as it travels through the output path
    typedef struct packed {
        kind_t               kind;
        logic [7:0]          position;
        logic [6:0]          char_code;
        logic                is_last_char;
        logic [8:0]          word_length;
        logic [CLASS_W-1:0]  word_class;
        logic [GROUP_W-1:0]  word_group;
        logic                classified;
        logic                group_seen;
    } result_t;

    // Read-modify-write request to the used-group bitmap
    typedef struct packed {
        logic               en;
        logic [GROUP_W-1:0] grp;
    } bm_req_t;

endpackage

### rtl/fcvd_bitmap.sv
// Used-group bitmap: one-bit synchronous RAM with read-first test-and-set port.
// Clears itself after reset, one entry per cycle. Depends on fcvd_pkg.
module fcvd_bitmap #(
    parameter int GROUPS = 4096
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  fcvd_pkg::bm_req_t req,
    output logic             seen,
    output logic             busy
);

    localparam int AW = (GROUPS > 1) ? $clog2(GROUPS) : 1;

    logic          mem [GROUPS];
    logic [AW-1:0] clr_cnt_reg;
    logic          busy_reg;
    logic          rd_data_reg;
    logic [AW-1:0] addr;

    assign addr = req.grp[AW-1:0];

    // Clearing sweep control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
            busy_reg    <= 1'b1;
        end else if (busy_reg) begin
            if (clr_cnt_reg == AW'(GROUPS - 1)) begin
                busy_reg <= 1'b0;
            end else begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    // Storage: clear during sweep, otherwise read old bit and set it
    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            mem[clr_cnt_reg] <= 1'b0;
        end else if (req.en) begin
            rd_data_reg <= mem[addr];
            mem[addr]   <= 1'b1;
        end
    end

    assign seen = rd_data_reg;
    assign busy = busy_reg;

endmodule

### rtl/fcvd_outq.sv
// Two-entry result queue that decouples the decoder from the result channel.
// Depends on fcvd_pkg for the result type.
module fcvd_outq (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  fcvd_pkg::result_t push_data,
    output logic              room,
    output logic              m_valid,
    input  logic              m_ready,
    output fcvd_pkg::result_t head
);

    fcvd_pkg::result_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       pop;

    assign room    = (cnt_reg != 2'd2);
    assign m_valid = (cnt_reg != 2'd0);
    assign pop     = m_valid && m_ready;
    assign head    = entry_reg[rd_ptr_reg];

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 2'd1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/front_coded_vocab_decoder.sv
// Front-coded word-list decoder: one byte per cycle sustained, s_ready permitting.
// Path: a result passes through the decode register, then the output queue, before it
// appears on m_*; the bitmap test-and-set answer comes from a registered RAM read.
// Reset (synchronous, aresetn low) clears control state, then the used-group
// RAM is swept entry by entry with s_ready low; cfg writes are taken throughout.
module front_coded_vocab_decoder #(
    parameter int BUF_CHARS = 256,
    parameter int GROUPS    = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [7:0]  m_position,
    output logic [6:0]  m_char_code,
    output logic        m_is_last_char,
    output logic [8:0]  m_word_length,
    output logic [11:0] m_word_class,
    output logic [11:0] m_word_group,
    output logic        m_classified,
    output logic        m_group_seen
);

    localparam int BW    = $clog2(BUF_CHARS + 1);
    localparam int LEN_W = (BW > 9) ? BW : 9;

    typedef enum logic [2:0] {
        PH_COUNT = 3'd0,
        PH_CHAR  = 3'd1,
        PH_INFO0 = 3'd2,
        PH_INFO1 = 3'd3,
        PH_INFO2 = 3'd4
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [LEN_W-1:0]   word_len_reg, word_len_next;
    logic [15:0]        info_high_reg, info_high_next;
    logic               simple_mode_reg;

    logic               p_valid_reg;
    logic               p_chk_reg;
    fcvd_pkg::result_t  p_res_reg;

    fcvd_pkg::result_t  res;
    logic               res_valid;
    logic               res_chk;
    logic               accept;
    logic               p_move;
    logic [LEN_W-1:0]   len_inc;
    logic [LEN_W-1:0]   byte_ext;
    logic [11:0]        grp;
    logic               grp_in_range;

    fcvd_pkg::bm_req_t  bm_req;
    logic               bm_seen;
    logic               bm_busy;
    fcvd_pkg::result_t  q_data;
    fcvd_pkg::result_t  q_head;
    logic               q_room;

    assign p_move  = p_valid_reg && q_room;
    assign s_ready = !bm_busy && (!p_valid_reg || q_room);
    assign accept  = s_valid && s_ready;

    assign len_inc      = word_len_reg + 1'b1;
    assign byte_ext     = LEN_W'(s_in_byte);
    assign grp          = {info_high_reg[3:0], s_in_byte};
    assign grp_in_range = ({1'b0, grp} < 13'(GROUPS));

    // Per-byte decode
    always_comb begin
        phase_next     = phase_reg;
        word_len_next  = word_len_reg;
        info_high_next = info_high_reg;
        res            = '0;
        res_valid      = 1'b0;
        res_chk        = 1'b0;
        unique case (phase_reg)
            PH_CHAR: begin
                res_valid        = 1'b1;
                res.kind         = fcvd_pkg::KIND_CHAR;
                res.position     = word_len_reg[7:0];
                res.char_code    = s_in_byte[6:0];
                res.is_last_char = s_in_byte[7] || (len_inc >= LEN_W'(BUF_CHARS));
                word_len_next    = len_inc;
                if (res.is_last_char) begin
                    phase_next = PH_INFO0;
                end
            end
            PH_INFO0: begin
                info_high_next = {s_in_byte, 8'h00};
                phase_next     = PH_INFO1;
            end
            PH_INFO1: begin
                info_high_next = {info_high_reg[15:8], s_in_byte};
                phase_next     = PH_INFO2;
            end
            PH_INFO2: begin
                res_valid       = 1'b1;
                res.kind        = fcvd_pkg::KIND_REC;
                res.word_length = word_len_reg[8:0];
                if (!simple_mode_reg) begin
                    res.word_class = info_high_reg[15:4];
                    res.word_group = grp;
                    res.classified = 1'b1;
                    res_chk        = grp_in_range;
                end
                phase_next = PH_COUNT;
            end
            default: begin
                // prefix count; unused codes land here too
                if (byte_ext > word_len_reg) begin
                    res_valid  = 1'b1;
                    res.kind   = fcvd_pkg::KIND_ERR;
                    phase_next = PH_COUNT;
                end else begin
                    word_len_next = byte_ext;
                    phase_next    = (byte_ext >= LEN_W'(BUF_CHARS)) ? PH_INFO0 : PH_CHAR;
                end
            end
        endcase
    end

    assign bm_req.en  = accept && res_chk;
    assign bm_req.grp = grp;

    // Decoder state, mode register and decode stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_COUNT;
            word_len_reg    <= '0;
            info_high_reg   <= '0;
            simple_mode_reg <= 1'b0;
            p_valid_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                simple_mode_reg <= cfg_wdata;
            end
            if (accept) begin
                phase_reg     <= phase_next;
                word_len_reg  <= word_len_next;
                info_high_reg <= info_high_next;
                p_valid_reg   <= res_valid;
            end else if (p_move) begin
                p_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p_res_reg <= res;
            p_chk_reg <= res_chk;
        end
    end

    fcvd_bitmap #(
        .GROUPS (GROUPS)
    ) u_bitmap (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (bm_req),
        .seen    (bm_seen),
        .busy    (bm_busy)
    );

    // Merge the bitmap answer as the request leaves the decode stage
    always_comb begin
        q_data            = p_res_reg;
        q_data.group_seen = p_chk_reg && bm_seen;
    end

    fcvd_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (p_move),
        .push_data (q_data),
        .room      (q_room),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .head      (q_head)
    );

    assign m_kind         = q_head.kind;
    assign m_position     = q_head.position;
    assign m_char_code    = q_head.char_code;
    assign m_is_last_char = q_head.is_last_char;
    assign m_word_length  = q_head.word_length;
    assign m_word_class   = q_head.word_class;
    assign m_word_group   = q_head.word_group;
    assign m_classified   = q_head.classified;
    assign m_group_seen   = q_head.group_seen;

    // Checks
    a_busy_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        bm_busy |-> !s_ready)
        else $error("request accepted during bitmap clear");

    a_rec_reaches_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && phase_reg == PH_INFO2) |=>
            (p_valid_reg && p_res_reg.kind == fcvd_pkg::KIND_REC))
        else $error("word record lost at decode stage");

    a_seen_needs_class: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_group_seen) |-> m_classified)
        else $error("group_seen without classified record");

    a_char_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == fcvd_pkg::KIND_CHAR) |->
            (!m_classified && m_word_length == 9'd0))
        else $error("record fields set on a character result");

endmodule
